FILE: rtl/tracking_wheel_odometry_unit_defines.svh
// Assertion macros shared by the checker of the tracking wheel odometry unit.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef TRACKING_WHEEL_ODOMETRY_UNIT_DEFINES_SVH
`define TRACKING_WHEEL_ODOMETRY_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define TWOU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a signal keeps its value in the cycle after a condition.
`define TWOU_ASSERT_HOLD(label, cond, sig, msg) \
   `TWOU_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

FILE: rtl/twou_pkg.sv
// Types, constants and the arctangent table of the tracking wheel odometry unit.
// No dependencies.
package twou_pkg;

   typedef enum logic [3:0] {
      ST_IDLE, ST_THETA, ST_DELTA, ST_DRAD, ST_OFFSET, ST_MOD, ST_FOLD, ST_CORDIC,
      ST_COSSIN, ST_MUL_Y0, ST_MUL_Y1, ST_MUL_X0, ST_MUL_X1, ST_DONE
   } state_type;

   localparam logic [1:0] CSR_IMU_GAIN    = 2'd0;
   localparam logic [1:0] CSR_BACK_OFFSET = 2'd1;
   localparam logic [1:0] CSR_WHEEL_EN    = 2'd2;
   localparam logic [1:0] CSR_UNUSED      = 2'd3;

   localparam int REQ_DATA_W = 232;
   localparam int RSP_DATA_W = 160;
   localparam int ANG_W      = 27;

   localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;
   localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
   localparam logic signed [ANG_W-1:0] DEG90  = 27'sd5898240;
   localparam logic signed [31:0] DEG_TO_RAD  = 32'sd74961321;

   // A full turn is 45 * 2^19 in Q16.16 degrees. The angle above bit 19 is
   // reduced modulo 45 through a rounded reciprocal of 2^36 / 45.
   localparam int                 MOD_SHIFT   = 19;
   localparam logic signed [31:0] RECIP45     = 32'sd1527099483;
   localparam logic [5:0]         RECIP_SHIFT = 6'd36;

   function automatic logic [ANG_W-1:0] atan_deg(input logic [4:0] idx);
      logic [ANG_W-1:0] v;
      unique case (idx)
         5'd0: v = 27'd2949120;
         5'd1: v = 27'd1740967;
         5'd2: v = 27'd919879;
         5'd3: v = 27'd466945;
         5'd4: v = 27'd234379;
         5'd5: v = 27'd117304;
         5'd6: v = 27'd58666;
         5'd7: v = 27'd29335;
         5'd8: v = 27'd14668;
         5'd9: v = 27'd7334;
         5'd10: v = 27'd3667;
         5'd11: v = 27'd1833;
         5'd12: v = 27'd917;
         5'd13: v = 27'd458;
         5'd14: v = 27'd229;
         5'd15: v = 27'd115;
         5'd16: v = 27'd57;
         5'd17: v = 27'd29;
         5'd18: v = 27'd14;
         5'd19: v = 27'd7;
         5'd20: v = 27'd4;
         5'd21: v = 27'd2;
         5'd22: v = 27'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/tracking_wheel_odometry_unit.sv
// Tracking wheel odometry: wheel and IMU deltas, CORDIC rotation, pose accumulation.
// Depends on twou_pkg.
// A tick item passes through the theta, delta, radian, offset, modulo, fold, CORDIC,
// cos/sin and multiply states before its result is loaded; a set-pose item goes
// straight to the result state. The unit is ready for the next item in the cycle after
// the result is loaded, and waits in the result state while the output is held.
// The CORDIC runs one step per cycle; all products go through one shared multiplier.
// Synchronous active-high reset restores the register defaults and clears the pose.
module tracking_wheel_odometry_unit
   import twou_pkg::*;
#(
   parameter int WORD_WIDTH   = 32,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // left_distance, right_distance, back_distance, imu_rotation, imu_calibrating,
   // set_x, set_y, set_heading, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x, out_y, out_heading, out_forward_delta, out_side_delta
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wdata
);

   localparam int W    = WORD_WIDTH;
   localparam int PW   = WORD_WIDTH + 32;
   localparam int XW   = 34;
   localparam int CW   = $clog2(CORDIC_STEPS);
   localparam longint unsigned X0 = 64'd652032874 +
      ((64'd434688583 + (64'd1 << (2 * CORDIC_STEPS - 1))) >> (2 * CORDIC_STEPS));
   localparam logic signed [XW-1:0] XINIT = XW'(X0);

   state_type state_ff, state_in;

   logic [15:0]         gain_ff, gain_in;
   logic signed [23:0]  offset_ff, offset_in;
   logic [2:0]          en_ff, en_in;
   logic signed [W-1:0] l_ff, l_in, r_ff, r_in, b_ff, b_in, rot_ff, rot_in;
   logic                calib_ff, calib_in;
   logic signed [W-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [W-1:0] prev_b_ff, prev_b_in, prev_h_ff, prev_h_in;
   logic signed [W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_h_ff, pos_h_in;
   logic signed [W-1:0] fwd_ff, fwd_in, side_ff, side_in;
   logic signed [W-1:0] theta_ff, theta_in, db_ff, db_in, ddeg_ff, ddeg_in;
   logic signed [W-1:0] drad_ff, drad_in;
   logic signed [W-1:0] ang_ff, ang_in, q_ff, q_in;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic                neg_ff, neg_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic signed [31:0]  c_ff, c_in, s_ff, s_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [W-1:0]  mul_a;
   logic signed [31:0]   mul_b;
   logic [5:0]           sh_amt;
   logic signed [PW-1:0] mul_p, mul_sum;
   logic signed [W-1:0]  mul_res;
   logic                 accept, load_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      mul_a  = fwd_ff;
      mul_b  = c_ff;
      sh_amt = 6'd30;
      unique case (state_ff)
         ST_THETA: begin
            mul_a  = rot_ff;
            mul_b  = signed'({16'b0, gain_ff});
            sh_amt = 6'd14;
         end
         ST_DRAD: begin
            mul_a  = ddeg_ff;
            mul_b  = DEG_TO_RAD;
            sh_amt = 6'd32;
         end
         ST_OFFSET: begin
            mul_a  = drad_ff;
            mul_b  = 32'(offset_ff);
            sh_amt = 6'd16;
         end
         ST_MOD: begin
            mul_a  = ang_ff >>> MOD_SHIFT;
            mul_b  = RECIP45;
            sh_amt = RECIP_SHIFT;
         end
         ST_MUL_Y1: begin
            mul_a = side_ff;
            mul_b = s_ff;
         end
         ST_MUL_X0: begin
            mul_a = side_ff;
            mul_b = c_ff;
         end
         ST_MUL_X1: begin
            mul_a = fwd_ff;
            mul_b = s_ff;
         end
         default: begin
         end
      endcase
      mul_p   = PW'(mul_a) * PW'(mul_b);
      mul_sum = mul_p + (PW'(1) << (sh_amt - 6'd1));
      mul_res = W'(mul_sum >>> sh_amt);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = req_tuser ? ST_DONE : ST_THETA;
         ST_THETA:  state_in = ST_DELTA;
         ST_DELTA:  state_in = ST_DRAD;
         ST_DRAD:   state_in = ST_OFFSET;
         ST_OFFSET: state_in = ST_MOD;
         ST_MOD:    state_in = ST_FOLD;
         ST_FOLD:   state_in = ST_CORDIC;
         ST_CORDIC: if (cnt_ff == CW'(CORDIC_STEPS - 1)) state_in = ST_COSSIN;
         ST_COSSIN: state_in = ST_MUL_Y0;
         ST_MUL_Y0: state_in = ST_MUL_Y1;
         ST_MUL_Y1: state_in = ST_MUL_X0;
         ST_MUL_X0: state_in = ST_MUL_X1;
         ST_MUL_X1: state_in = ST_DONE;
         ST_DONE:   if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic signed [W:0]       lr_sum;
      logic signed [W-1:0]     dl, dr, hi, rem_hi;
      logic signed [ANG_W-1:0] rr;
      logic [4:0]              step;
      gain_in = gain_ff;   offset_in = offset_ff; en_in = en_ff;
      l_in = l_ff;         r_in = r_ff;           b_in = b_ff;
      rot_in = rot_ff;     calib_in = calib_ff;
      prev_l_in = prev_l_ff; prev_r_in = prev_r_ff;
      prev_b_in = prev_b_ff; prev_h_in = prev_h_ff;
      pos_x_in = pos_x_ff; pos_y_in = pos_y_ff;   pos_h_in = pos_h_ff;
      fwd_in = fwd_ff;     side_in = side_ff;     theta_in = theta_ff;
      db_in = db_ff;       ddeg_in = ddeg_ff;     drad_in = drad_ff;
      ang_in = ang_ff;     q_in = q_ff;
      x_in = x_ff;         y_in = y_ff;           z_in = z_ff;
      neg_in = neg_ff;     cnt_in = cnt_ff;       c_in = c_ff;   s_in = s_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      lr_sum = '0;
      dl     = '0;
      dr     = '0;
      hi     = '0;
      rem_hi = '0;
      rr     = '0;
      step   = 5'(cnt_ff);

      if (csr_we) begin
         unique case (csr_index)
            CSR_IMU_GAIN:    gain_in = csr_wdata[15:0];
            CSR_BACK_OFFSET: offset_in = signed'(csr_wdata);
            CSR_WHEEL_EN:    en_in = csr_wdata[2:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  pos_x_in = W'(signed'(req_tdata[160:129]));
                  pos_y_in = W'(signed'(req_tdata[192:161]));
                  pos_h_in = W'(signed'(req_tdata[224:193]));
               end
               l_in     = en_ff[0] ? W'(signed'(req_tdata[31:0])) : '0;
               r_in     = en_ff[1] ? W'(signed'(req_tdata[63:32])) : '0;
               b_in     = en_ff[2] ? W'(signed'(req_tdata[95:64])) : '0;
               rot_in   = W'(signed'(req_tdata[127:96]));
               calib_in = req_tdata[128];
            end
         end
         ST_THETA: theta_in = calib_ff ? '0 : -mul_res;
         ST_DELTA: begin
            dl        = l_ff - prev_l_ff;
            dr        = r_ff - prev_r_ff;
            lr_sum    = (W+1)'(dl) + (W+1)'(dr);
            fwd_in    = lr_sum[W:1];
            db_in     = b_ff - prev_b_ff;
            ddeg_in   = theta_ff - prev_h_ff;
            pos_h_in  = pos_h_ff + (theta_ff - prev_h_ff);
            prev_l_in = l_ff;
            prev_r_in = r_ff;
            prev_b_in = b_ff;
            prev_h_in = theta_ff;
         end
         ST_DRAD: drad_in = mul_res;
         ST_OFFSET: begin
            side_in = db_ff - mul_res;
            ang_in  = pos_h_ff - (ddeg_ff >>> 1);
         end
         ST_MOD: q_in = mul_res;
         ST_FOLD: begin
            hi     = ang_ff >>> MOD_SHIFT;
            rem_hi = hi - ((q_ff <<< 5) + (q_ff <<< 3) + (q_ff <<< 2) + q_ff);
            rr     = signed'({rem_hi[7:0], ang_ff[MOD_SHIFT-1:0]});
            if (rr < 0) rr = rr + DEG360;
            if (rr >= DEG180) rr = rr - DEG360;
            neg_in = 1'b0;
            if (rr > DEG90) begin
               rr = rr - DEG180;
               neg_in = 1'b1;
            end else if (rr < -DEG90) begin
               rr = rr + DEG180;
               neg_in = 1'b1;
            end
            z_in   = rr;
            x_in   = XINIT;
            y_in   = '0;
            cnt_in = '0;
         end
         ST_CORDIC: begin
            if (z_ff >= 0) begin
               x_in = x_ff - (y_ff >>> cnt_ff);
               y_in = y_ff + (x_ff >>> cnt_ff);
               z_in = z_ff - signed'(atan_deg(step));
            end else begin
               x_in = x_ff + (y_ff >>> cnt_ff);
               y_in = y_ff - (x_ff >>> cnt_ff);
               z_in = z_ff + signed'(atan_deg(step));
            end
            cnt_in = cnt_ff + CW'(1);
         end
         ST_COSSIN: begin
            c_in = 32'(neg_ff ? -x_ff : x_ff);
            s_in = 32'(neg_ff ? -y_ff : y_ff);
         end
         ST_MUL_Y0: pos_y_in = pos_y_ff + mul_res;
         ST_MUL_Y1: pos_y_in = pos_y_ff - mul_res;
         ST_MUL_X0: pos_x_in = pos_x_ff + mul_res;
         ST_MUL_X1: pos_x_in = pos_x_ff + mul_res;
         ST_DONE: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {32'(side_ff), 32'(fwd_ff), 32'(pos_h_ff),
                               32'(pos_y_ff), 32'(pos_x_ff)};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= 16'd16384;
         offset_ff    <= '0;
         en_ff        <= 3'b111;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         prev_b_ff    <= '0;
         prev_h_ff    <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         pos_h_ff     <= '0;
         fwd_ff       <= '0;
         side_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         en_ff        <= en_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         prev_b_ff    <= prev_b_in;
         prev_h_ff    <= prev_h_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_h_ff     <= pos_h_in;
         fwd_ff       <= fwd_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      r_ff        <= r_in;
      b_ff        <= b_in;
      rot_ff      <= rot_in;
      calib_ff    <= calib_in;
      theta_ff    <= theta_in;
      db_ff       <= db_in;
      ddeg_ff     <= ddeg_in;
      drad_ff     <= drad_in;
      ang_ff      <= ang_in;
      q_ff        <= q_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: rtl/twou_checker.sv
// Port-level checks for the tracking wheel odometry unit, bound to the top level.
// Depends on tracking_wheel_odometry_unit_defines.svh and twou_pkg.
`include "tracking_wheel_odometry_unit_defines.svh"

module twou_checker
   import twou_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `TWOU_ASSERT(a_rsp_valid_holds, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "result dropped")
   `TWOU_ASSERT_HOLD(a_rsp_data_holds, rsp_tvalid && !rsp_tready, rsp_tdata, "result changed")
   `TWOU_ASSERT(a_busy_after_accept, req_tvalid && req_tready |=> !req_tready, "item overlap")
   `TWOU_ASSERT(a_reset_state, $past(reset) |-> !rsp_tvalid && req_tready, "bad reset state")

endmodule

bind tracking_wheel_odometry_unit twou_checker u_twou_checker (.*);

FILE: tb/twou_checker.sv
// Checker for the tracking wheel odometry unit: watches the request, result and register
// ports, predicts each pose item and compares it field by field. Depends on twou_pkg.
module tb_twou_checker
   import twou_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wdata,
   output int                    errors,
   output int                    pending,
   output int                    poses_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 16;
   localparam longint ATAN_TAB [0:15] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   typedef struct packed {
      logic [31:0] side;
      logic [31:0] fwd;
      logic [31:0] heading;
      logic [31:0] y;
      logic [31:0] x;
   } pose_type;

   pose_type    pose_queue[$];
   logic [15:0] gain;
   logic [23:0] offset;
   logic [2:0]  wheel_en;
   longint      last_l, last_r, last_b, last_theta;
   longint      px, py, ph, fwd, side;

   function automatic longint wrap32(longint v);
      return longint'($signed(v[31:0]));
   endfunction

   function automatic longint round_shift(longint a, longint b, int s);
      return (a * b + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   task automatic rotate_unit(input longint angle, output longint c, output longint s);
      longint r, x, y, z, t;
      bit     neg;
      r = angle % longint'(DEG360);
      neg = 0;
      if (r < 0) r += longint'(DEG360);
      if (r >= longint'(DEG180)) r -= longint'(DEG360);
      if (r > longint'(DEG90)) begin
         r -= longint'(DEG180);
         neg = 1;
      end else if (r < -longint'(DEG90)) begin
         r += longint'(DEG180);
         neg = 1;
      end
      x = 652032874 + ((longint'(434688583) + (longint'(1) <<< (2 * STEPS - 1)))
          >>> (2 * STEPS));
      y = 0;
      z = r;
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_TAB[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_TAB[i];
         end
         x = t;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   task automatic predict_pose(input logic cmd, input logic [REQ_DATA_W-1:0] d);
      longint   l, r, b, theta, dl, dr, db, ddeg, drad, ang, c, s, dx, dy;
      pose_type p;
      if (cmd) begin
         px = longint'($signed(d[160:129]));
         py = longint'($signed(d[192:161]));
         ph = longint'($signed(d[224:193]));
      end else begin
         l = wheel_en[0] ? longint'($signed(d[31:0])) : 0;
         r = wheel_en[1] ? longint'($signed(d[63:32])) : 0;
         b = wheel_en[2] ? longint'($signed(d[95:64])) : 0;
         theta = 0;
         if (!d[128])
            theta = wrap32(-((longint'($signed(d[127:96])) * longint'(gain) + 8192) >>> 14));
         dl = wrap32(l - last_l);
         dr = wrap32(r - last_r);
         db = wrap32(b - last_b);
         ddeg = wrap32(theta - last_theta);
         ph = wrap32(ph + ddeg);
         last_l = l;
         last_r = r;
         last_b = b;
         last_theta = theta;
         fwd = wrap32((dl + dr) >>> 1);
         drad = round_shift(ddeg, longint'(DEG_TO_RAD), 32);
         side = wrap32(db - round_shift(drad, longint'($signed(offset)), 16));
         ang = wrap32(ph - (ddeg >>> 1));
         rotate_unit(ang, c, s);
         dy = round_shift(fwd, c, 30) - round_shift(side, s, 30);
         dx = round_shift(side, c, 30) + round_shift(fwd, s, 30);
         py = wrap32(py + dy);
         px = wrap32(px + dx);
      end
      p.x = px[31:0];
      p.y = py[31:0];
      p.heading = ph[31:0];
      p.fwd = fwd[31:0];
      p.side = side[31:0];
      pose_queue.push_back(p);
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      poses_checked = 0;
   end

   always @(posedge clock) begin
      pose_type p, a;
      if (reset) begin
         gain = 16'd16384;
         offset = '0;
         wheel_en = 3'd7;
         last_l = 0;
         last_r = 0;
         last_b = 0;
         last_theta = 0;
         px = 0;
         py = 0;
         ph = 0;
         fwd = 0;
         side = 0;
         pose_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMU_GAIN:    gain = csr_wdata[15:0];
               CSR_BACK_OFFSET: offset = csr_wdata;
               CSR_WHEEL_EN:    wheel_en = csr_wdata[2:0];
               default:         ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            a = rsp_tdata;
            if (pose_queue.size() == 0) begin
               $error("Result item arrived with no item expected");
               errors++;
            end else begin
               p = pose_queue.pop_front();
               check_field("out_x", p.x, a.x);
               check_field("out_y", p.y, a.y);
               check_field("out_heading", p.heading, a.heading);
               check_field("out_forward_delta", p.fwd, a.fwd);
               check_field("out_side_delta", p.side, a.side);
               poses_checked++;
            end
         end
         if (req_tvalid && req_tready)
            predict_pose(req_tuser, req_tdata);
      end
      pending = pose_queue.size();
   end
endmodule

FILE: tb/tb_top.sv
// Top of the odometry unit testbench: clock, reset, register writes and item stimulus
// under several idling phases; the verdict comes from tb_twou_checker. Depends on twou_pkg.
module tb_top
   import twou_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE = 32 + 16 + 12 + 8;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                  clock, reset;
   logic                  req_tvalid, req_tready, req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid, rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [23:0]           csr_wdata;
   int                    errors, pending, poses_checked;
   int                    send_idle_pct, recv_stall_pct, hold_cycles, quiet_cycles;
   int                    ticks_sent, poses_set, csr_writes;
   logic [31:0]           cum_l, cum_r, cum_b, cum_rot;

   tracking_wheel_odometry_unit dut (.*);

   tb_twou_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata,
      .errors, .pending, .poses_checked
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d items outstanding", pending);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic cmd, input logic [31:0] l, r, b, rot,
                            input logic cal, input logic [31:0] sx, sy, sh);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, sh, sy, sx, cal, rot, b, r, l};
      do @(posedge clock); while (!req_tready);
      if (cmd) poses_set++;
      else ticks_sent++;
   endtask

   task automatic send_tick(input logic [31:0] l, r, b, rot, input logic cal);
      send_item(1'b0, l, r, b, rot, cal, $urandom, $urandom, $urandom);
   endtask

   task automatic send_pose(input logic [31:0] sx, sy, sh);
      send_item(1'b1, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                sx, sy, sh);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   task automatic configure(input logic [15:0] gain, input logic [23:0] off,
                            input logic [2:0] en);
      drain();
      csr_write(CSR_IMU_GAIN, {8'd0, gain});
      csr_write(CSR_BACK_OFFSET, off);
      csr_write(CSR_WHEEL_EN, {21'd0, en});
   endtask

   task automatic random_items(input int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 8) begin
            send_pose($urandom, $urandom, $urandom);
         end else if (k < 16) begin
            cum_l = $urandom;
            cum_r = $urandom;
            cum_b = $urandom;
            cum_rot = $urandom;
            send_tick(cum_l, cum_r, cum_b, cum_rot, 1'($urandom_range(1)));
         end else begin
            cum_l += $signed($urandom_range(262144)) - 131072;
            cum_r += $signed($urandom_range(262144)) - 131072;
            cum_b += $signed($urandom_range(131072)) - 65536;
            cum_rot += $signed($urandom_range(2 * 1966080)) - 1966080;
            send_tick(cum_l, cum_r, cum_b, cum_rot, $urandom_range(99) < 10);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      quiet_cycles = 0;
      ticks_sent = 0;
      poses_set = 0;
      csr_writes = 0;
      cum_l = 0;
      cum_r = 0;
      cum_b = 0;
      cum_rot = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_tick(0, 0, 0, 0, 1'b0);
      send_tick(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h005A_0000, 1'b0);
      send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h00B4_0000, 1'b1);
      send_tick(32'h0010_0000, 32'h0010_0000, 32'h0, 32'hFF4C_0000, 1'b0);
      send_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h0168_0000);
      send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_tick(32'h0020_0000, 32'h0020_0000, 32'h0010_0000, 32'h0000_0001, 1'b0);
      send_pose(0, 0, 32'h005A_0000);
      send_tick(32'h0030_0000, 32'h0030_0000, 32'h0, 32'h0000_0001, 1'b1);
      configure(16'd0, 24'h800000, 3'd0);
      send_tick(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'h1111_1111, 1'b0);
      send_tick(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      configure(16'hFFFF, 24'h7FFFFF, 3'd7);
      send_tick(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h002D_0000, 1'b0);
      send_tick(32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'hFFD3_0000, 1'b0);
      send_tick(32'h7FFF_0000, 32'h8000_FFFF, 32'h1000_0000, 32'h7FFF_FFFF, 1'b0);
      drain();
      csr_write(CSR_UNUSED, 24'hFFFFFF);
      send_tick(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         case (ph)
            0: configure(16'd16384, 24'd0, 3'd7);
            1: configure(16'd0, 24'h800000, 3'd5);
            2: configure(16'hFFFF, 24'h7FFFFF, 3'd3);
            default: configure(16'($urandom), 24'($urandom), 3'($urandom));
         endcase
         if (ph == 2) begin
            hold_cycles = 400;
            random_items(20);
            drain();
         end
         random_items(75);
      end

      drain();
      $display("Covered %0d ticks and %0d pose loads over %0d register writes,", ticks_sent,
               poses_set, csr_writes);
      $display("with %0d results compared under four idling phases.", poses_checked);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

FILE: tracking_wheel_odometry_unit.f
+incdir+rtl
rtl/twou_pkg.sv
rtl/tracking_wheel_odometry_unit.sv
rtl/twou_checker.sv
tb/twou_checker.sv
tb/tb_top.sv
